// ----- hw/rtl/iirdf1_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the DF1 IIR filter.
package iirdf1_pkg;

   localparam int TAPS      = 9;
   localparam int TAP_CNT   = 2 * TAPS - 1;
   localparam int TAP_W     = $clog2(TAP_CNT);
   localparam int IDX_W     = $clog2(TAPS);
   localparam int HIDX_W    = (TAPS - 1 > 1) ? $clog2(TAPS - 1) : 1;
   localparam int OP_W      = 2;
   localparam int CIDX_W    = 4;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + $clog2(TAP_CNT + 1) + 1;
   localparam int FRAC_DROP = 24;

   typedef enum logic [OP_W-1:0] {
      OP_FILTER = 2'd0,
      OP_NUM_WR = 2'd1,
      OP_DEN_WR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND
   } state_type;

   typedef struct packed {
      logic shift_in;
      logic wr_num;
      logic wr_den;
      logic issue;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic tap_last;
      logic out_full;
   } stat_type;

endpackage

// ----- hw/rtl/iirdf1_ctrl.sv -----
// Controller state machine: decodes requests and sequences the shared multiply-accumulate.
module iirdf1_ctrl
   import iirdf1_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OP_W-1:0]     req_operation,
   output logic                req_ready,
   input  stat_type            stat,
   output cmd_type             cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_operation == OP_FILTER)) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (stat.tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_ROUND;
         ST_ROUND: begin
            if (!stat.out_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.shift_in = (req_operation == OP_FILTER);
               cmd.wr_num   = (req_operation == OP_NUM_WR);
               cmd.wr_den   = (req_operation == OP_DEN_WR);
            end
         end
         ST_MAC:   cmd.issue  = 1'b1;
         ST_DRAIN: cmd.issue  = 1'b0;
         ST_ROUND: cmd.finish = !stat.out_full;
         default:  cmd        = '0;
      endcase
   end

endmodule

// ----- hw/rtl/iirdf1_datapath.sv -----
// Datapath: coefficient and history registers, shared multiplier, accumulator, round and clip.
module iirdf1_datapath
   import iirdf1_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic [CIDX_W-1:0]        req_coef_index,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_filtered,
   output logic                     rsp_saturated
);

   logic signed [DATA_W-1:0] num_ff  [TAPS];
   logic signed [DATA_W-1:0] den_ff  [TAPS-1];
   logic signed [DATA_W-1:0] xhist_ff[TAPS];
   logic signed [DATA_W-1:0] yhist_ff[TAPS-1];

   logic [TAP_W-1:0]         tap_ff, tap_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_valid_ff, prod_sub_ff, prod_sub_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_filtered_ff;
   logic                     rsp_saturated_ff;

   logic [TAP_W-1:0]         x_pos, d_pos, y_pos;
   logic signed [DATA_W-1:0] coef_sel, data_sel;
   logic signed [ACC_W-1:0]  addend, rounded;
   logic signed [ACC_W-FRAC_DROP-1:0] q;
   logic [ACC_W-FRAC_DROP-DATA_W:0]   q_top;
   logic                     sat;
   logic signed [DATA_W-1:0] res;
   logic                     num_hit, den_hit;

   // Tap select: numerator taps first, then the denominator taps (subtracted)
   always_comb begin
      x_pos       = TAP_W'(TAPS - 1) - tap_ff;
      d_pos       = tap_ff - TAP_W'(TAPS);
      y_pos       = TAP_W'(TAPS - 2) - d_pos;
      prod_sub_in = (tap_ff >= TAP_W'(TAPS));
      if (prod_sub_in) begin
         coef_sel = den_ff[HIDX_W'(d_pos)];
         data_sel = yhist_ff[HIDX_W'(y_pos)];
      end else begin
         coef_sel = num_ff[IDX_W'(tap_ff)];
         data_sel = xhist_ff[IDX_W'(x_pos)];
      end
      prod_in = coef_sel * data_sel;
      tap_in  = cmd.shift_in ? '0 : (cmd.issue ? tap_ff + 1'b1 : tap_ff);
   end

   always_comb begin
      addend = prod_sub_ff ? -ACC_W'(prod_ff) : ACC_W'(prod_ff);
      if (cmd.shift_in) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + addend;
      end else begin
         acc_in = acc_ff;
      end
   end

   // Round half up, drop the extra fraction bits, clip to the 32-bit range
   always_comb begin
      rounded = acc_ff + (ACC_W'(1) <<< (FRAC_DROP - 1));
      q       = rounded[ACC_W-1:FRAC_DROP];
      q_top   = q[ACC_W-FRAC_DROP-1:DATA_W-1];
      sat     = !((&q_top) || (~|q_top));
      if (sat) begin
         res = q_top[ACC_W-FRAC_DROP-DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                             : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         res = q[DATA_W-1:0];
      end
   end

   always_comb begin
      num_hit = 32'(req_coef_index) < 32'(TAPS);
      den_hit = (req_coef_index != '0) && (32'(req_coef_index) < 32'(TAPS));
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            num_ff[i]   <= '0;
            xhist_ff[i] <= '0;
         end
         for (int i = 0; i < TAPS - 1; i++) begin
            den_ff[i]   <= '0;
            yhist_ff[i] <= '0;
         end
         tap_ff        <= '0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tap_ff        <= tap_in;
         prod_valid_ff <= cmd.issue;
         rsp_valid_ff  <= rsp_valid_in;
         if (cmd.wr_num && num_hit) begin
            num_ff[IDX_W'(req_coef_index)] <= req_value;
         end
         if (cmd.wr_den && den_hit) begin
            den_ff[HIDX_W'(req_coef_index - 1'b1)] <= req_value;
         end
         if (cmd.shift_in) begin
            for (int i = 0; i < TAPS - 1; i++) begin
               xhist_ff[i] <= xhist_ff[i+1];
            end
            xhist_ff[TAPS-1] <= req_value;
         end
         if (cmd.finish) begin
            for (int i = 0; i < TAPS - 2; i++) begin
               yhist_ff[i] <= yhist_ff[i+1];
            end
            yhist_ff[TAPS-2] <= res;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_sub_ff <= prod_sub_in;
      acc_ff      <= acc_in;
      if (cmd.finish) begin
         rsp_filtered_ff  <= res;
         rsp_saturated_ff <= sat;
      end
   end

   assign stat.tap_last = (tap_ff == TAP_W'(TAP_CNT - 1));
   assign stat.out_full = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

// ----- hw/rtl/iir_direct_form_one_filter.sv -----
// Top level of the direct form I IIR filter: controller plus datapath.
// A sample transfer starts a sweep over the 2*TAPS-1 taps by the single shared
// multiply-accumulate, then a drain and a round state; no request is taken until the
// result is finished. Coefficient writes are taken in the idle state without a sweep.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) zeroes both histories and all coefficients.
module iir_direct_form_one_filter
   import iirdf1_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [CIDX_W-1:0]        req_coef_index,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_filtered,
   output logic                     rsp_saturated
);

   cmd_type  cmd;
   stat_type stat;

   // Decode requests and step through the taps
   iirdf1_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // Hold coefficients and histories, multiply-accumulate, round and clip
   iirdf1_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_coef_index (req_coef_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered   (rsp_filtered),
      .rsp_saturated  (rsp_saturated)
   );

   // No request transfer while the multiply-accumulate runs
   a_busy_no_ready : assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !req_ready)
      else $error("request taken during tap sweep");

   // Never overwrite a result that is still waiting
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid && !rsp_ready))
      else $error("pending result overwritten");

   // A new result appears only after a finish command
   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result without finish");

   // A sample transfer starts the tap sweep on the next cycle
   a_sweep_starts : assert property (@(posedge clock) disable iff (reset)
      cmd.shift_in |=> cmd.issue)
      else $error("tap sweep did not start");

endmodule
